// ===== rtl/sldf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sync/length frame deframer.
// No dependencies; used by sldf_parser and the top level in rtl/.
package sldf_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int HEADER_BYTES = 8;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int WP_W         = ADDR_W + 1;   // write position may equal STORE_BYTES

  // Frame header offsets of the little-endian length
  localparam int LEN_LO_OFS = 6;
  localparam int LEN_HI_OFS = 7;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_OK         = 2'd1;
  localparam logic [1:0] ST_BAD_LEN    = 2'd2;

  localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0]  RST_SYNC_FIRST    = 8'hAA;
  localparam logic [7:0]  RST_SYNC_SECOND   = 8'h55;
  localparam logic [15:0] RST_PAYLOAD_LIMIT = 16'd1016;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [9:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        frame_ready;
    logic [15:0] frame_payload_len;
    logic [7:0]  read_data;
    logic [15:0] header_error_count;
    logic [15:0] length_error_count;
    logic [15:0] overflow_count;
    logic [15:0] timeout_count;
    logic [15:0] frame_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] payload_limit;
  } cfg_t;

  // Frame store port requests from the parser
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/sldf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sldf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sldf_parser.sv =====
`timescale 1ns / 1ps
// Frame parser: sync search, header walk, length check, counters.
// Depends on sldf_pkg; drives the frame store requests.
module sldf_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  sldf_pkg::in_t      in_data,
  input  sldf_pkg::cfg_t     cfg,
  output sldf_pkg::out_t     res,
  output logic               rd_hit,
  output sldf_pkg::mem_req_t mem
);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CRC_H   = 4'd2,
    PH_CRC_L   = 4'd3,
    PH_CMD     = 4'd4,
    PH_CTRL    = 4'd5,
    PH_LEN_L   = 4'd6,
    PH_LEN_H   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_READY   = 4'd9
  } phase_t;

  phase_t                      phase_r, phase_nxt, phase_eff;
  logic [sldf_pkg::WP_W-1:0]   wp_r, wp_nxt, pos, wp_inc;
  logic [15:0]                 exp_r, exp_nxt;
  logic [7:0]                  len_lo_r, len_lo_nxt;
  logic [15:0]                 herr_r, herr_nxt;
  logic [15:0]                 lerr_r, lerr_nxt;
  logic [15:0]                 ovf_r, ovf_nxt;
  logic [15:0]                 tmo_r, tmo_nxt;
  logic [15:0]                 frm_r, frm_nxt;
  logic [15:0]                 len_rx;
  logic [1:0]                  status;
  logic                        restart_first;
  logic [7:0]                  b;

  assign b      = in_data.data_byte;
  assign len_rx = {b, len_lo_r};

  always_comb begin
    phase_nxt     = phase_r;
    wp_nxt        = wp_r;
    exp_nxt       = exp_r;
    len_lo_nxt    = len_lo_r;
    herr_nxt      = herr_r;
    lerr_nxt      = lerr_r;
    ovf_nxt       = ovf_r;
    tmo_nxt       = tmo_r;
    frm_nxt       = frm_r;
    status        = sldf_pkg::ST_INCOMPLETE;
    rd_hit        = 1'b0;
    mem           = '0;
    phase_eff     = phase_r;
    pos           = wp_r;
    restart_first = 1'b0;
    wp_inc        = '0;

    unique case (sldf_pkg::req_t'(in_data.req_type))
      sldf_pkg::REQ_BYTE: begin
        // A held frame is dropped; a full store counts an overflow. Both restart.
        restart_first = (phase_r == PH_READY) || (phase_r > PH_READY) ||
                        (wp_r == sldf_pkg::WP_W'(sldf_pkg::STORE_BYTES));
        if (phase_r != PH_READY && phase_r <= PH_READY &&
            wp_r == sldf_pkg::WP_W'(sldf_pkg::STORE_BYTES)) begin
          ovf_nxt = ovf_r + 16'd1;
        end
        if (restart_first) begin
          phase_eff = PH_SYNC1;
          pos       = '0;
          exp_nxt   = '0;
        end
        wp_inc    = pos + sldf_pkg::WP_W'(1);
        mem.we    = 1'b1;
        mem.waddr = sldf_pkg::ADDR_W'(pos);
        mem.wdata = b;

        unique case (phase_eff)
          PH_SYNC1: begin
            if (b == cfg.sync_first) begin
              phase_nxt = PH_SYNC2;
              wp_nxt    = wp_inc;
            end else begin
              phase_nxt = PH_SYNC1;
              herr_nxt  = herr_r + 16'd1;
              wp_nxt    = '0;
            end
          end
          PH_SYNC2: begin
            if (b == cfg.sync_second) begin
              phase_nxt = PH_CRC_H;
              wp_nxt    = wp_inc;
            end else begin
              // resync: byte lands at offset 0 whether or not it is kept
              herr_nxt  = herr_r + 16'd1;
              exp_nxt   = '0;
              mem.waddr = '0;
              if (b == cfg.sync_first) begin
                phase_nxt = PH_SYNC2;
                wp_nxt    = sldf_pkg::WP_W'(1);
              end else begin
                phase_nxt = PH_SYNC1;
                wp_nxt    = '0;
              end
            end
          end
          PH_LEN_L: begin
            len_lo_nxt = b;
            phase_nxt  = PH_LEN_H;
            wp_nxt     = wp_inc;
          end
          PH_LEN_H: begin
            if (len_rx > cfg.payload_limit) begin
              lerr_nxt  = lerr_r + 16'd1;
              phase_nxt = PH_SYNC1;
              wp_nxt    = '0;
              exp_nxt   = '0;
              status    = sldf_pkg::ST_BAD_LEN;
            end else if (len_rx == 16'd0) begin
              exp_nxt   = len_rx;
              phase_nxt = PH_READY;
              wp_nxt    = wp_inc;
              frm_nxt   = frm_r + 16'd1;
              status    = sldf_pkg::ST_OK;
            end else begin
              exp_nxt   = len_rx;
              phase_nxt = PH_PAYLOAD;
              wp_nxt    = wp_inc;
            end
          end
          PH_PAYLOAD: begin
            wp_nxt = wp_inc;
            if (32'(wp_inc) - 32'(sldf_pkg::HEADER_BYTES) >= 32'(exp_r)) begin
              phase_nxt = PH_READY;
              frm_nxt   = frm_r + 16'd1;
              status    = sldf_pkg::ST_OK;
            end
          end
          PH_CRC_H: begin
            phase_nxt = PH_CRC_L;
            wp_nxt    = wp_inc;
          end
          PH_CRC_L: begin
            phase_nxt = PH_CMD;
            wp_nxt    = wp_inc;
          end
          PH_CMD: begin
            phase_nxt = PH_CTRL;
            wp_nxt    = wp_inc;
          end
          PH_CTRL: begin
            phase_nxt = PH_LEN_L;
            wp_nxt    = wp_inc;
          end
          default: begin
            phase_nxt = PH_SYNC1;
            wp_nxt    = '0;
          end
        endcase
      end
      sldf_pkg::REQ_TIMEOUT: begin
        if (phase_r != PH_SYNC1 && phase_r != PH_READY) begin
          tmo_nxt   = tmo_r + 16'd1;
          phase_nxt = PH_SYNC1;
          wp_nxt    = '0;
          exp_nxt   = '0;
        end
      end
      sldf_pkg::REQ_READ: begin
        mem.re    = 1'b1;
        mem.raddr = sldf_pkg::ADDR_W'(in_data.read_index);
        if (phase_r == PH_READY) begin
          status = sldf_pkg::ST_OK;
          rd_hit = 32'(in_data.read_index) < 32'(wp_r);
        end
      end
      sldf_pkg::REQ_RELEASE: begin
        if (phase_r == PH_READY) begin
          status    = sldf_pkg::ST_OK;
          phase_nxt = PH_SYNC1;
          wp_nxt    = '0;
          exp_nxt   = '0;
        end
      end
      default: begin
      end
    endcase

    res.status             = status;
    res.frame_ready        = (phase_nxt == PH_READY);
    res.frame_payload_len  = exp_nxt;
    res.read_data          = '0;
    res.header_error_count = herr_nxt;
    res.length_error_count = lerr_nxt;
    res.overflow_count     = ovf_nxt;
    res.timeout_count      = tmo_nxt;
    res.frame_count        = frm_nxt;

    // only enable the store when the beat is really taken
    mem.we = mem.we & take;
    mem.re = mem.re & take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      wp_r    <= '0;
      exp_r   <= '0;
      herr_r  <= '0;
      lerr_r  <= '0;
      ovf_r   <= '0;
      tmo_r   <= '0;
      frm_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      exp_r   <= exp_nxt;
      herr_r  <= herr_nxt;
      lerr_r  <= lerr_nxt;
      ovf_r   <= ovf_nxt;
      tmo_r   <= tmo_nxt;
      frm_r   <= frm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      len_lo_r <= len_lo_nxt;
    end
  end

endmodule

// ===== rtl/sync_length_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// Sync/length frame deframer top level: config registers, parser, frame store,
// result register. Depends on sldf_pkg, sldf_parser and sldf_ram.
// A result beat follows an accepted input beat in the next cycle. Throughput: one
// beat per cycle while out_stall is low; the result register takes a new beat while
// the held one leaves, and read data comes straight from the store's read register.
// Reset (synchronous, rst_n low): parser idle, counters zero, registers at defaults.
module sync_length_frame_deframer_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sldf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sldf_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);

  sldf_pkg::cfg_t     cfg_r;
  sldf_pkg::out_t     res, out_r;
  sldf_pkg::mem_req_t mem;
  logic               rd_hit, rd_hit_r;
  logic               out_valid_r, out_valid_nxt;
  logic               take;
  logic [7:0]         ram_q;

  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first    <= sldf_pkg::RST_SYNC_FIRST;
      cfg_r.sync_second   <= sldf_pkg::RST_SYNC_SECOND;
      cfg_r.payload_limit <= sldf_pkg::RST_PAYLOAD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sldf_pkg::CFG_SYNC_FIRST:    cfg_r.sync_first    <= cfg_wdata[7:0];
        sldf_pkg::CFG_SYNC_SECOND:   cfg_r.sync_second   <= cfg_wdata[7:0];
        sldf_pkg::CFG_PAYLOAD_LIMIT: cfg_r.payload_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sldf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .cfg     (cfg_r),
    .res     (res),
    .rd_hit  (rd_hit),
    .mem     (mem)
  );

  sldf_ram #(
    .WIDTH (8),
    .DEPTH (sldf_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (ram_q)
  );

  assign out_valid_nxt = take | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r    <= res;
      rd_hit_r <= rd_hit;
    end
  end

  // store read data stays put until the next read beat is taken
  always_comb begin
    out_data           = out_r;
    out_data.read_data = rd_hit_r ? ram_q : 8'd0;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== bench/sync_length_frame_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sync_length_frame_deframer_unit: a queue-fed driver, a scoreboard
// monitor and a cycle-free model of the frame parser. Depends on sldf_pkg and the rtl/ sources.
module sync_length_frame_deframer_unit_tb;

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CRC_H, PH_CRC_L, PH_CMD, PH_CTRL,
    PH_LEN_L, PH_LEN_H, PH_PAYLOAD, PH_HELD
  } phase_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  sldf_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  sldf_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [15:0]    cfg_wdata = '0;

  // Parser model state and its copy of the registers
  phase_t      phase;
  logic [10:0] wr_pos;
  logic [15:0] exp_len;
  logic [7:0]  store_img [sldf_pkg::STORE_BYTES];
  logic [15:0] hdr_errs, len_errs, overflows, tmo_aborts, frames;
  logic [7:0]  sync1_reg, sync2_reg;
  logic [15:0] limit_reg;

  sldf_pkg::in_t  pending_beats[$];
  sldf_pkg::out_t due_reports[$];
  sldf_pkg::out_t want_report;
  int   beats_added;
  int   mismatches = 0;
  bit   calm = 1'b0;

  sync_length_frame_deframer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------- model ----------------
  function automatic void clear_frame();
    phase   = PH_SYNC1;
    wr_pos  = '0;
    exp_len = '0;
  endfunction

  function automatic logic [1:0] absorb_byte(input logic [7:0] b);
    logic [1:0] st;
    st = sldf_pkg::ST_INCOMPLETE;
    if (phase == PH_HELD) clear_frame();
    if (wr_pos >= sldf_pkg::STORE_BYTES) begin
      overflows++;
      clear_frame();
    end
    store_img[wr_pos[sldf_pkg::ADDR_W-1:0]] = b;
    wr_pos++;
    case (phase)
      PH_SYNC1: begin
        if (b == sync1_reg) begin
          phase = PH_SYNC2;
        end else begin
          hdr_errs++;
          wr_pos = '0;
        end
      end
      PH_SYNC2: begin
        if (b == sync2_reg) begin
          phase = PH_CRC_H;
        end else begin
          hdr_errs++;
          clear_frame();
          // a repeated first sync byte starts a new header
          if (b == sync1_reg) begin
            store_img[0] = b;
            wr_pos = 11'd1;
            phase = PH_SYNC2;
          end
        end
      end
      PH_LEN_H: begin
        exp_len = {store_img[sldf_pkg::LEN_HI_OFS], store_img[sldf_pkg::LEN_LO_OFS]};
        if (exp_len > limit_reg) begin
          len_errs++;
          clear_frame();
          st = sldf_pkg::ST_BAD_LEN;
        end else if (exp_len == 16'd0) begin
          phase = PH_HELD;
          frames++;
          st = sldf_pkg::ST_OK;
        end else begin
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (int'(wr_pos) - sldf_pkg::HEADER_BYTES >= int'(exp_len)) begin
          phase = PH_HELD;
          frames++;
          st = sldf_pkg::ST_OK;
        end
      end
      default: phase = phase_t'(phase + 4'd1);
    endcase
    return st;
  endfunction

  function automatic sldf_pkg::out_t predict_report(input sldf_pkg::in_t beat);
    sldf_pkg::out_t r;
    r = '0;
    case (sldf_pkg::req_t'(beat.req_type))
      sldf_pkg::REQ_BYTE: r.status = absorb_byte(beat.data_byte);
      sldf_pkg::REQ_TIMEOUT: begin
        if (phase != PH_SYNC1 && phase != PH_HELD) begin
          tmo_aborts++;
          clear_frame();
        end
      end
      sldf_pkg::REQ_READ: begin
        if (phase == PH_HELD) begin
          r.status = sldf_pkg::ST_OK;
          if (beat.read_index < wr_pos) r.read_data = store_img[beat.read_index];
        end
      end
      default: begin
        if (phase == PH_HELD) begin
          r.status = sldf_pkg::ST_OK;
          clear_frame();
        end
      end
    endcase
    r.frame_ready        = (phase == PH_HELD);
    r.frame_payload_len  = exp_len;
    r.header_error_count = hdr_errs;
    r.length_error_count = len_errs;
    r.overflow_count     = overflows;
    r.timeout_count      = tmo_aborts;
    r.frame_count        = frames;
    return r;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_reports.push_back(predict_report(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99, 0) >= 30)) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        want_report = due_reports.pop_front();
        compare_field("status", want_report.status, out_data.status);
        compare_field("frame_ready", want_report.frame_ready, out_data.frame_ready);
        compare_field("frame_payload_len", want_report.frame_payload_len,
                      out_data.frame_payload_len);
        compare_field("read_data", want_report.read_data, out_data.read_data);
        compare_field("header_error_count", want_report.header_error_count,
                      out_data.header_error_count);
        compare_field("length_error_count", want_report.length_error_count,
                      out_data.length_error_count);
        compare_field("overflow_count", want_report.overflow_count, out_data.overflow_count);
        compare_field("timeout_count", want_report.timeout_count, out_data.timeout_count);
        compare_field("frame_count", want_report.frame_count, out_data.frame_count);
      end
    end
    out_stall <= rst_n && !calm && ($urandom_range(99, 0) < 30);
  end

  // ---------------- stimulus ----------------
  task automatic push_beat(input sldf_pkg::req_t req, input logic [7:0] b,
                           input logic [9:0] idx);
    sldf_pkg::in_t beat;
    beat.req_type   = req;
    beat.data_byte  = b;
    beat.read_index = idx;
    pending_beats.push_back(beat);
    beats_added++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_beat(sldf_pkg::REQ_BYTE, b, 10'($urandom));
  endtask

  task automatic push_read(input logic [9:0] idx);
    push_beat(sldf_pkg::REQ_READ, 8'($urandom), idx);
  endtask

  task automatic push_ctl(input sldf_pkg::req_t req);
    push_beat(req, 8'($urandom), 10'($urandom));
  endtask

  task automatic push_frame(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] len, input int sent);
    push_byte(s1);
    push_byte(s2);
    repeat (4) push_byte(8'($urandom));  // crc, command, control
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    repeat (sent) push_byte(8'($urandom));
  endtask

  task automatic poke_held(input int len);
    int top;
    top = (len + 9 > 1023) ? 1023 : len + 9;
    repeat ($urandom_range(4, 0)) begin
      if ($urandom_range(9, 0) < 7) push_read(10'($urandom_range(top, 0)));
      else push_read(10'($urandom));
    end
    case ($urandom_range(3, 0))
      0, 1: push_ctl(sldf_pkg::REQ_RELEASE);
      2: push_ctl(sldf_pkg::REQ_TIMEOUT);
      default: ;  // next byte drops the held frame
    endcase
  endtask

  task automatic add_traffic(input logic [7:0] s1, input logic [7:0] s2, input int limit,
                             input int count);
    int pick, len, sent, cap;
    bit fits, cut;
    beats_added = 0;
    while (beats_added < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          cap = (limit < 12) ? limit : 12;
          len = $urandom_range(cap, 0);
        end else if (pick < 80) begin
          cap = (limit < 40) ? limit : 40;
          len = $urandom_range(cap, 0);
        end else if (pick < 92 && limit < 65535) begin
          len = limit + 1 + $urandom_range(300, 0);
          if (len > 65535) len = 65535;
        end else begin
          len = $urandom_range(65535, 0);
        end
        fits = (len <= limit);
        sent = len;
        cut  = 1'b0;
        if (len > 40) begin
          sent = $urandom_range(20, 0);  // long lengths stay cheap
          cut  = fits;
        end else if (fits && len > 0 && $urandom_range(9, 0) == 0) begin
          sent = $urandom_range(len - 1, 0);
          cut  = 1'b1;
        end
        push_frame(s1, s2, 16'(len), sent);
        if (cut && $urandom_range(4, 0) != 0) push_ctl(sldf_pkg::REQ_TIMEOUT);
        else if (fits && !cut) poke_held(len);
      end else if (pick < 70) begin
        repeat ($urandom_range(6, 1))
          push_beat(sldf_pkg::req_t'($urandom_range(3, 0)), 8'($urandom), 10'($urandom));
      end else if (pick < 80) begin
        push_byte(s1);
        if ($urandom_range(1, 0) != 0) begin
          push_byte(8'($urandom));
        end else begin
          cap = (limit < 8) ? limit : 8;
          len = $urandom_range(cap, 0);
          push_frame(s1, s2, 16'(len), len);
          poke_held(len);
        end
      end else if (pick < 90) begin
        push_byte(s1);
        push_byte(s2);
        repeat ($urandom_range(5, 0)) push_byte(8'($urandom));
        push_ctl(sldf_pkg::REQ_TIMEOUT);
      end else begin
        case ($urandom_range(2, 0))
          0: push_read(10'($urandom));
          1: push_ctl(sldf_pkg::REQ_RELEASE);
          default: push_ctl(sldf_pkg::REQ_TIMEOUT);
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || due_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sldf_pkg::CFG_SYNC_FIRST:    sync1_reg = val[7:0];
      sldf_pkg::CFG_SYNC_SECOND:   sync2_reg = val[7:0];
      sldf_pkg::CFG_PAYLOAD_LIMIT: limit_reg = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2, input logic [15:0] lim,
                           input int count, input bit quiet, input int big_len);
    // upper byte of the sync writes is junk the block must drop
    write_reg(sldf_pkg::CFG_SYNC_FIRST, {8'($urandom), s1});
    write_reg(sldf_pkg::CFG_SYNC_SECOND, {8'($urandom), s2});
    write_reg(sldf_pkg::CFG_PAYLOAD_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    calm = quiet;
    if (big_len > 0) begin
      push_frame(s1, s2, 16'(big_len), 1016);
      if (big_len <= lim) begin
        push_read(10'd1023);
        push_read(10'd0);
        push_ctl(sldf_pkg::REQ_RELEASE);
      end else begin
        // oversize length is rejected at the header; a short frame follows
        push_frame(s1, s2, 16'd4, 4);
        poke_held(4);
      end
    end
    add_traffic(s1, s2, lim, count);
    wait_drained();
  endtask

  initial begin
    sync1_reg  = sldf_pkg::RST_SYNC_FIRST;
    sync2_reg  = sldf_pkg::RST_SYNC_SECOND;
    limit_reg  = sldf_pkg::RST_PAYLOAD_LIMIT;
    clear_frame();
    hdr_errs   = '0;
    len_errs   = '0;
    overflows  = '0;
    tmo_aborts = '0;
    frames     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle requests, header errors, resync, zero length, reads,
    // byte while held, wrong second sync, partial timeout, oversize length
    push_read(10'd1023);
    push_ctl(sldf_pkg::REQ_RELEASE);
    push_ctl(sldf_pkg::REQ_TIMEOUT);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hAA);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    push_byte(8'h78);
    push_byte(8'h00);
    push_byte(8'h00);
    push_read(10'd0);
    push_read(10'd8);
    push_byte(8'hAA);
    push_byte(8'h11);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_ctl(sldf_pkg::REQ_TIMEOUT);
    push_frame(8'hAA, 8'h55, 16'd1017, 0);
    wait_drained();

    add_traffic(sldf_pkg::RST_SYNC_FIRST, sldf_pkg::RST_SYNC_SECOND,
                sldf_pkg::RST_PAYLOAD_LIMIT, 60);
    wait_drained();
    run_phase(8'h00, 8'hFF, 16'd0, 100, 1'b1, 0);
    run_phase(8'hFF, 8'h00, 16'hFFFF, 30, 1'b0, 1100);
    run_phase(8'h5A, 8'h5A, 16'd20, 30, 1'b0, 0);
    run_phase(sldf_pkg::RST_SYNC_FIRST, sldf_pkg::RST_SYNC_SECOND,
              sldf_pkg::RST_PAYLOAD_LIMIT, 30, 1'b0, 1016);
    repeat (2)
      run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(200, 0)), 30, 1'b0, 0);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sldf_pkg.sv
rtl/sldf_ram.sv
rtl/sldf_parser.sv
rtl/sync_length_frame_deframer_unit.sv
bench/sync_length_frame_deframer_unit_tb.sv
